FILE: hw/rtl/ufe_pkg.sv
// Shared types and constants of the union-find engine.
// Holds the micro-op and jump-condition codes, the control word and the condition flags.
// Standalone; used by ufe_useq and union_find_engine.
package ufe_pkg;

    localparam int UPC_W   = 4;
    localparam int RANK_W  = 4;
    localparam int ELEM_W  = 10;
    localparam int COUNT_W = 11;
    localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

    typedef enum logic [2:0] {
        UOP_WAIT,
        UOP_LOAD,
        UOP_FIND,
        UOP_COMPRESS,
        UOP_RANK,
        UOP_LINK,
        UOP_EMIT,
        UOP_NOP
    } uop_t;

    typedef enum logic [2:0] {
        JC_NEXT,
        JC_ALWAYS,
        JC_NO_ITEM,
        JC_BAD,
        JC_WALKING,
        JC_NO_UNION,
        JC_OUT_BUSY
    } jcond_t;

    typedef struct packed {
        uop_t             op;
        logic             sel_b;
        jcond_t           jcond;
        logic [UPC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic item_accepted;
        logic bad;
        logic walking;
        logic no_union;
        logic out_busy;
    } ufe_cond_t;

endpackage

FILE: hw/rtl/union_find_engine.sv
// Union-find engine: union by rank with path compression; depends on ufe_pkg and ufe_useq.
// Flow: walk a to its root and compress its path, then the same for b; a merging union then
// reads both root ranks and links them, and a flagged index goes straight to emit.
// Throughput: one transaction at a time, the next taken only once the emit step retires; emit
// holds while an earlier result still waits on m_tready.
// Reset: a clearing pass rewrites all NUM_ELEMENTS entries of both memories; s_tready stays low.
module union_find_engine #(
    parameter int NUM_ELEMENTS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,   // element_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,     // elem_a[9:0], elem_b[19:10], zero fill
    input  logic        s_tuser,     // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata      // same_set[0], merged[1], bad_index[2], zero fill
);
    import ufe_pkg::*;

    localparam int IDX_W = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
    localparam logic [16:0] NUM_ELEM_V = 17'(NUM_ELEMENTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ELEMENTS - 1);

    logic [IDX_W-1:0]  parent_mem [NUM_ELEMENTS];
    logic [RANK_W-1:0] rank_mem [NUM_ELEMENTS];

    ucode_t    ctrl;
    ufe_cond_t cond;

    logic [COUNT_W-1:0] element_count_reg;
    logic               clearing_reg;
    logic [IDX_W-1:0]   clr_idx_reg;
    logic               cmd_reg;
    logic               bad_reg, bad_next;
    logic [IDX_W-1:0]   a_reg, b_reg;
    logic [IDX_W-1:0]   node_reg, node_next;
    logic [IDX_W-1:0]   root_a_reg, root_a_next;
    logic [IDX_W-1:0]   root_b_reg, root_b_next;
    logic [RANK_W-1:0]  rank_a_reg, rank_a_next;
    logic               merged_reg, merged_next;
    logic               out_valid_reg, out_valid_next;
    logic [2:0]         out_data_reg, out_data_next;

    logic [IDX_W-1:0]   parent_rdata_reg;
    logic [RANK_W-1:0]  rank_rdata_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               p_we;
    logic [IDX_W-1:0]   p_waddr, p_wdata;
    logic               r_we;
    logic [IDX_W-1:0]   r_waddr;
    logic [RANK_W-1:0]  r_wdata;

    logic               accept;
    logic [ELEM_W-1:0]  in_a, in_b;
    logic               in_bad;
    logic [IDX_W-1:0]   root_sel;
    logic               same;
    logic               out_busy;
    logic               a_is_low;
    logic [IDX_W-1:0]   hi_root, lo_root;

    ufe_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cond    (cond),
        .ctrl    (ctrl)
    );

    assign in_a     = s_tdata[9:0];
    assign in_b     = s_tdata[19:10];
    assign s_tready = (ctrl.op == UOP_WAIT) && !clearing_reg;
    assign accept   = s_tvalid && s_tready;
    assign in_bad   = (11'(in_a) >= element_count_reg) || (11'(in_b) >= element_count_reg)
                   || (17'(in_a) >= NUM_ELEM_V) || (17'(in_b) >= NUM_ELEM_V);
    assign root_sel = ctrl.sel_b ? root_b_reg : root_a_reg;
    assign same     = (root_a_reg == root_b_reg);
    assign out_busy = out_valid_reg && !m_tready;
    assign a_is_low = (rank_a_reg < rank_rdata_reg);
    assign hi_root  = a_is_low ? root_b_reg : root_a_reg;
    assign lo_root  = a_is_low ? root_a_reg : root_b_reg;

    always_comb begin
        cond.item_accepted = accept;
        cond.bad           = bad_reg;
        cond.no_union      = cmd_reg || same;
        cond.out_busy      = out_busy;
        if (ctrl.op == UOP_FIND) begin
            cond.walking = (parent_rdata_reg != node_reg);
        end else begin
            cond.walking = (node_reg != root_sel) && (parent_rdata_reg != node_reg);
        end
    end

    always_comb begin
        bad_next       = bad_reg;
        node_next      = node_reg;
        root_a_next    = root_a_reg;
        root_b_next    = root_b_reg;
        rank_a_next    = rank_a_reg;
        merged_next    = merged_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        rd_addr        = node_reg;
        p_we           = 1'b0;
        p_waddr        = node_reg;
        p_wdata        = root_sel;
        r_we           = 1'b0;
        r_waddr        = hi_root;
        r_wdata        = rank_a_reg + 1'b1;
        unique case (ctrl.op)
            UOP_WAIT: begin
                bad_next    = in_bad;
                merged_next = 1'b0;
            end
            UOP_LOAD: begin
                node_next = ctrl.sel_b ? b_reg : a_reg;
                rd_addr   = node_next;
            end
            UOP_FIND: begin
                rd_addr = parent_rdata_reg;
                if (parent_rdata_reg != node_reg) begin
                    node_next = parent_rdata_reg;
                end else if (ctrl.sel_b) begin
                    root_b_next = node_reg;
                end else begin
                    root_a_next = node_reg;
                end
            end
            UOP_COMPRESS: begin
                rd_addr = parent_rdata_reg;
                if (node_reg != root_sel) begin
                    p_we      = 1'b1;
                    node_next = parent_rdata_reg;
                end
            end
            UOP_RANK: begin
                rd_addr = root_sel;
                if (ctrl.sel_b) begin
                    rank_a_next = rank_rdata_reg;
                end
            end
            UOP_LINK: begin
                p_we        = 1'b1;
                p_waddr     = lo_root;
                p_wdata     = hi_root;
                r_we        = (rank_a_reg == rank_rdata_reg) && (rank_a_reg < RANK_MAX);
                merged_next = 1'b1;
            end
            UOP_EMIT: begin
                if (!out_busy) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {bad_reg, merged_reg, !bad_reg && same};
                end
            end
            UOP_NOP: begin
            end
            default: begin
            end
        endcase
        if (clearing_reg) begin
            p_we    = 1'b1;
            p_waddr = clr_idx_reg;
            p_wdata = clr_idx_reg;
            r_we    = 1'b1;
            r_waddr = clr_idx_reg;
            r_wdata = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_we) begin
            parent_mem[p_waddr] <= p_wdata;
        end
        parent_rdata_reg <= parent_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (r_we) begin
            rank_mem[r_waddr] <= r_wdata;
        end
        rank_rdata_reg <= rank_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            element_count_reg <= COUNT_RESET;
            clearing_reg      <= 1'b1;
            clr_idx_reg       <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                element_count_reg <= cfg_wdata;
            end
            if (clearing_reg) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_IDX) begin
                    clearing_reg <= 1'b0;
                end
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= s_tuser;
            a_reg   <= IDX_W'(in_a);
            b_reg   <= IDX_W'(in_b);
        end
        bad_reg      <= bad_next;
        node_reg     <= node_next;
        root_a_reg   <= root_a_next;
        root_b_reg   <= root_b_next;
        rank_a_reg   <= rank_a_next;
        merged_reg   <= merged_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_data_reg};

    assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !s_tready)
        else $error("transaction taken during clearing pass");

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("second transaction taken while busy");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == UOP_COMPRESS && p_we && !clearing_reg) |-> (node_reg != root_sel))
        else $error("compression rewrote the root");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[1] && (m_tdata[0] || m_tdata[2])))
        else $error("merge reported with same set or flagged index");

endmodule

FILE: hw/rtl/ufe_useq.sv
// Microcode sequencer of the union-find engine: step counter, control ROM, jumps.
// Depends on ufe_pkg for the control word and condition flag types.
module ufe_useq (
    input  logic              aclk,
    input  logic              aresetn,
    input  ufe_pkg::ufe_cond_t cond,
    output ufe_pkg::ucode_t   ctrl
);
    import ufe_pkg::*;

    localparam logic [UPC_W-1:0] STEP_IDLE = 4'd0;
    localparam logic [UPC_W-1:0] STEP_FIND_A = 4'd2;
    localparam logic [UPC_W-1:0] STEP_COMP_A = 4'd4;
    localparam logic [UPC_W-1:0] STEP_FIND_B = 4'd6;
    localparam logic [UPC_W-1:0] STEP_COMP_B = 4'd8;
    localparam logic [UPC_W-1:0] STEP_EMIT = 4'd12;

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic             take_jump;

    function automatic ucode_t rom(input logic [UPC_W-1:0] addr);
        ucode_t w;
        w = '{op: UOP_NOP, sel_b: 1'b0, jcond: JC_ALWAYS, target: STEP_IDLE};
        unique case (addr)
            4'd0:  w = '{op: UOP_WAIT,     sel_b: 1'b0, jcond: JC_NO_ITEM,  target: STEP_IDLE};
            4'd1:  w = '{op: UOP_LOAD,     sel_b: 1'b0, jcond: JC_BAD,      target: STEP_EMIT};
            4'd2:  w = '{op: UOP_FIND,     sel_b: 1'b0, jcond: JC_WALKING,  target: STEP_FIND_A};
            4'd3:  w = '{op: UOP_LOAD,     sel_b: 1'b0, jcond: JC_NEXT,     target: STEP_IDLE};
            4'd4:  w = '{op: UOP_COMPRESS, sel_b: 1'b0, jcond: JC_WALKING,  target: STEP_COMP_A};
            4'd5:  w = '{op: UOP_LOAD,     sel_b: 1'b1, jcond: JC_NEXT,     target: STEP_IDLE};
            4'd6:  w = '{op: UOP_FIND,     sel_b: 1'b1, jcond: JC_WALKING,  target: STEP_FIND_B};
            4'd7:  w = '{op: UOP_LOAD,     sel_b: 1'b1, jcond: JC_NEXT,     target: STEP_IDLE};
            4'd8:  w = '{op: UOP_COMPRESS, sel_b: 1'b1, jcond: JC_WALKING,  target: STEP_COMP_B};
            4'd9:  w = '{op: UOP_RANK,     sel_b: 1'b0, jcond: JC_NO_UNION, target: STEP_EMIT};
            4'd10: w = '{op: UOP_RANK,     sel_b: 1'b1, jcond: JC_NEXT,     target: STEP_IDLE};
            4'd11: w = '{op: UOP_LINK,     sel_b: 1'b0, jcond: JC_NEXT,     target: STEP_IDLE};
            4'd12: w = '{op: UOP_EMIT,     sel_b: 1'b0, jcond: JC_OUT_BUSY, target: STEP_EMIT};
            default: w = '{op: UOP_NOP,    sel_b: 1'b0, jcond: JC_ALWAYS,   target: STEP_IDLE};
        endcase
        return w;
    endfunction

    assign ctrl = rom(upc_reg);

    always_comb begin
        unique case (ctrl.jcond)
            JC_NEXT:     take_jump = 1'b0;
            JC_ALWAYS:   take_jump = 1'b1;
            JC_NO_ITEM:  take_jump = !cond.item_accepted;
            JC_BAD:      take_jump = cond.bad;
            JC_WALKING:  take_jump = cond.walking;
            JC_NO_UNION: take_jump = cond.no_union;
            JC_OUT_BUSY: take_jump = cond.out_busy;
            default:     take_jump = 1'b1;
        endcase
        upc_next = take_jump ? ctrl.target : upc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= STEP_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == UOP_WAIT && !cond.item_accepted) |=> (upc_reg == STEP_IDLE))
        else $error("sequencer left idle without a transaction");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == UOP_EMIT && !cond.out_busy) |=> (ctrl.op == UOP_NOP))
        else $error("emit step did not retire");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == UOP_LOAD && !ctrl.sel_b && cond.bad) |=> (ctrl.op == UOP_EMIT))
        else $error("flagged transaction touched the tables");

endmodule

FILE: verif/union_find_engine_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of union_find_engine: a directed table, then random phases of
// unions and queries, checked against a shadow disjoint-set model. Depends on ufe_pkg.
module union_find_engine_test;
    import ufe_pkg::*;

    localparam int NUM_ELEMENTS = 1024;

    typedef enum bit {
        CMD_UNION = 1'b0,
        CMD_QUERY = 1'b1
    } uf_cmd_t;

    typedef enum bit {
        ROW_ITEM,
        ROW_COUNT
    } row_kind_t;

    typedef struct packed {
        logic bad_index;
        logic merged;
        logic same_set;
    } verdict_t;

    localparam verdict_t VERDICT_SPLIT  = 3'b000;
    localparam verdict_t VERDICT_SAME   = 3'b001;
    localparam verdict_t VERDICT_MERGED = 3'b010;
    localparam verdict_t VERDICT_BAD    = 3'b100;

    typedef struct {
        row_kind_t kind;
        uf_cmd_t   cmd;
        int        elem_a;
        int        elem_b;
        int        value;
        bit        typed;
        verdict_t  verdict;
    } directed_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [10:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;     // elem_a[9:0], elem_b[19:10], zero fill
    logic        s_tuser;     // cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;     // same_set[0], merged[1], bad_index[2], zero fill

    logic [ELEM_W-1:0]  shadow_parent [NUM_ELEMENTS];
    logic [RANK_W-1:0]  shadow_rank   [NUM_ELEMENTS];
    logic [COUNT_W-1:0] shadow_count;
    verdict_t           awaited_verdicts [$];
    directed_row_t      directed_rows [$];
    int                 mismatches = 0;
    bit                 steady = 0;

    union_find_engine #(
        .NUM_ELEMENTS(NUM_ELEMENTS)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #8_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= 100) begin
            $display("mismatch at %0t: %s", $time, what);
        end
    endtask

    function automatic int next_link(int node);
        if (int'(shadow_parent[node]) >= NUM_ELEMENTS) begin
            return node;
        end
        return int'(shadow_parent[node]);
    endfunction

    function automatic int chase_root(int node);
        int steps;
        int nxt;
        steps = 0;
        while (steps < NUM_ELEMENTS) begin
            nxt = next_link(node);
            if (nxt == node) break;
            node = nxt;
            steps++;
        end
        return node;
    endfunction

    function automatic void flatten_path(int node, int root);
        int steps;
        int nxt;
        steps = 0;
        while (steps < NUM_ELEMENTS && node != root) begin
            nxt = next_link(node);
            shadow_parent[node] = ELEM_W'(root);
            if (nxt == node) break;
            node = nxt;
            steps++;
        end
    endfunction

    function automatic verdict_t predict_verdict(uf_cmd_t cmd, int a, int b);
        int       lim;
        int       ra;
        int       rb;
        int       t;
        verdict_t v;
        lim = (shadow_count > NUM_ELEMENTS) ? NUM_ELEMENTS : int'(shadow_count);
        if (a >= lim || b >= lim) begin
            return VERDICT_BAD;
        end
        ra = chase_root(a);
        flatten_path(a, ra);
        rb = chase_root(b);
        flatten_path(b, rb);
        v = VERDICT_SPLIT;
        v.same_set = (ra == rb);
        if (cmd == CMD_UNION && ra != rb) begin
            if (shadow_rank[ra] < shadow_rank[rb]) begin
                t = ra;
                ra = rb;
                rb = t;
            end
            shadow_parent[rb] = ELEM_W'(ra);
            if (shadow_rank[ra] == shadow_rank[rb] && shadow_rank[ra] < RANK_MAX) begin
                shadow_rank[ra] = shadow_rank[ra] + 1'b1;
            end
            v.merged = 1'b1;
        end
        return v;
    endfunction

    function automatic int pick_index(int lim);
        if (lim > 0 && $urandom_range(0, 99) < 85) begin
            return $urandom_range(0, lim - 1);
        end
        return $urandom_range(0, NUM_ELEMENTS - 1);
    endfunction

    function automatic directed_row_t item_row(uf_cmd_t cmd, int a, int b, bit typed,
                                               verdict_t verdict);
        directed_row_t r;
        r.kind    = ROW_ITEM;
        r.cmd     = cmd;
        r.elem_a  = a;
        r.elem_b  = b;
        r.value   = 0;
        r.typed   = typed;
        r.verdict = verdict;
        return r;
    endfunction

    function automatic directed_row_t count_row(int value);
        directed_row_t r;
        r = item_row(CMD_QUERY, 0, 0, 1'b0, VERDICT_SPLIT);
        r.kind  = ROW_COUNT;
        r.value = value;
        return r;
    endfunction

    task automatic send_item(uf_cmd_t cmd, int a, int b, bit typed, verdict_t given);
        verdict_t v;
        if (!steady && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0000, ELEM_W'(b), ELEM_W'(a)};
        do @(posedge aclk); while (!s_tready);
        v = predict_verdict(cmd, a, b);
        awaited_verdicts.push_back(typed ? given : v);
    endtask

    task automatic set_count(int value);
        s_tvalid <= 1'b0;
        while (awaited_verdicts.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= COUNT_W'(value);
        @(posedge aclk);
        cfg_we       <= 1'b0;
        shadow_count = COUNT_W'(value);
    endtask

    // result side: check each transaction, stall in random bursts outside the steady phase
    initial begin
        int       stall_left;
        verdict_t got;
        verdict_t want;
        stall_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got = verdict_t'(m_tdata[2:0]);
                if (awaited_verdicts.size() == 0) begin
                    flag_mismatch("result transaction with nothing pending");
                end else begin
                    want = awaited_verdicts.pop_front();
                    if (got.same_set !== want.same_set)
                        flag_mismatch($sformatf("same_set %b, want %b",
                                                got.same_set, want.same_set));
                    if (got.merged !== want.merged)
                        flag_mismatch($sformatf("merged %b, want %b",
                                                got.merged, want.merged));
                    if (got.bad_index !== want.bad_index)
                        flag_mismatch($sformatf("bad_index %b, want %b",
                                                got.bad_index, want.bad_index));
                end
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (!steady && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(1, 13) - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int            p;
        int            n;
        int            lim;
        int            phase_counts[$];
        uf_cmd_t       cmd;
        directed_row_t row;

        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= CMD_UNION;
        for (int i = 0; i < NUM_ELEMENTS; i++) begin
            shadow_parent[i] = ELEM_W'(i);
            shadow_rank[i]   = '0;
        end
        shadow_count = COUNT_RESET;

        directed_rows.push_back(item_row(CMD_QUERY, 0, 0, 1'b1, VERDICT_SAME));
        directed_rows.push_back(item_row(CMD_QUERY, 0, 1023, 1'b1, VERDICT_SPLIT));
        directed_rows.push_back(item_row(CMD_UNION, 0, 1023, 1'b1, VERDICT_MERGED));
        directed_rows.push_back(item_row(CMD_UNION, 1023, 0, 1'b1, VERDICT_SAME));
        directed_rows.push_back(item_row(CMD_UNION, 5, 5, 1'b1, VERDICT_SAME));
        directed_rows.push_back(item_row(CMD_UNION, 1, 2, 1'b0, VERDICT_SPLIT));
        directed_rows.push_back(item_row(CMD_UNION, 3, 4, 1'b0, VERDICT_SPLIT));
        directed_rows.push_back(item_row(CMD_UNION, 1, 3, 1'b0, VERDICT_SPLIT));
        directed_rows.push_back(item_row(CMD_UNION, 6, 1, 1'b0, VERDICT_SPLIT));
        directed_rows.push_back(item_row(CMD_QUERY, 6, 4, 1'b0, VERDICT_SPLIT));
        directed_rows.push_back(item_row(CMD_UNION, 682, 341, 1'b0, VERDICT_SPLIT));
        directed_rows.push_back(item_row(CMD_QUERY, 2, 1023, 1'b0, VERDICT_SPLIT));
        directed_rows.push_back(count_row(5));
        directed_rows.push_back(item_row(CMD_QUERY, 4, 0, 1'b0, VERDICT_SPLIT));
        directed_rows.push_back(item_row(CMD_UNION, 5, 0, 1'b1, VERDICT_BAD));
        directed_rows.push_back(item_row(CMD_UNION, 0, 5, 1'b1, VERDICT_BAD));
        directed_rows.push_back(item_row(CMD_QUERY, 1023, 1023, 1'b1, VERDICT_BAD));
        directed_rows.push_back(count_row(0));
        directed_rows.push_back(item_row(CMD_QUERY, 0, 0, 1'b1, VERDICT_BAD));
        directed_rows.push_back(count_row(1));
        directed_rows.push_back(item_row(CMD_QUERY, 0, 0, 1'b1, VERDICT_SAME));
        directed_rows.push_back(item_row(CMD_UNION, 0, 1, 1'b1, VERDICT_BAD));
        directed_rows.push_back(count_row(2047));
        directed_rows.push_back(item_row(CMD_QUERY, 1023, 1023, 1'b1, VERDICT_SAME));
        directed_rows.push_back(item_row(CMD_UNION, 1023, 682, 1'b0, VERDICT_SPLIT));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_COUNT) begin
                set_count(row.value);
            end else begin
                send_item(row.cmd, row.elem_a, row.elem_b, row.typed, row.verdict);
            end
        end

        phase_counts = '{16, 1024, 3, 2, 2047, 1, 1024};
        phase_counts[3] = $urandom_range(2, 1023);
        for (p = 0; p < phase_counts.size(); p++) begin
            set_count(phase_counts[p]);
            steady = (p == phase_counts.size() - 1);
            lim = (phase_counts[p] > NUM_ELEMENTS) ? NUM_ELEMENTS : phase_counts[p];
            for (n = 0; n < 200; n++) begin
                if ($urandom_range(0, 99) < 60) begin
                    cmd = CMD_UNION;
                end else begin
                    cmd = CMD_QUERY;
                end
                send_item(cmd, pick_index(lim), pick_index(lim), 1'b0, VERDICT_SPLIT);
            end
        end

        s_tvalid <= 1'b0;
        while (awaited_verdicts.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/ufe_pkg.sv
hw/rtl/ufe_useq.sv
hw/rtl/union_find_engine.sv
verif/union_find_engine_test.sv
